// ===== sv/tlcc_pkg.sv =====
// Package: shared types and constants for the trajectory line-crossing counter.
package tlcc_pkg;

   localparam int unsigned CNT_BITS = 16;
   localparam int unsigned PACK_BITS = 12;
   localparam int unsigned LINE_BITS = 64;
   localparam int unsigned LINE_REGS = 4;
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LINE_COUNT = 3'd0;
   localparam int signed MARGIN = 10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
   } status_type;

endpackage

// ===== sv/tlcc_datapath.sv =====
// Datapath: one line's crossing test over several cycles with a shared multiplier.
module tlcc_datapath
   import tlcc_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [LINE_BITS-1:0]  line_reg,
   input  logic [COORD_BITS-1:0] head_x,
   input  logic [COORD_BITS-1:0] head_y,
   input  logic [COORD_BITS-1:0] tail_x,
   input  logic [COORD_BITS-1:0] tail_y,
   output logic                  went_in,
   output logic                  went_out
);

   localparam int unsigned DW = COORD_BITS + 1;        // coordinate difference
   localparam int unsigned PW = 2 * DW + 2;            // S, D, product of diffs
   localparam int unsigned MW = PW;                     // multiplier operand width
   localparam int unsigned WW = 4 * PW + 8;             // wide compare width
   localparam int unsigned SW = 5;

   // step codes of the sequence
   localparam logic [SW-1:0] S_P0 = 5'd0;
   localparam logic [SW-1:0] S_P1 = 5'd1;
   localparam logic [SW-1:0] S_P2 = 5'd2;
   localparam logic [SW-1:0] S_P3 = 5'd3;
   localparam logic [SW-1:0] S_P4 = 5'd4;
   localparam logic [SW-1:0] S_P5 = 5'd5;
   localparam logic [SW-1:0] S_P6 = 5'd6;
   localparam logic [SW-1:0] S_P7 = 5'd7;
   localparam logic [SW-1:0] S_P8 = 5'd8;
   localparam logic [SW-1:0] S_P9 = 5'd9;
   localparam logic [SW-1:0] S_LO = 5'd10;
   localparam logic [SW-1:0] S_HI = 5'd11;
   localparam logic [SW-1:0] S_RL = 5'd12;
   localparam logic [SW-1:0] S_RH = 5'd13;
   localparam logic [SW-1:0] S_DEC = 5'd14;
   localparam logic [SW-1:0] S_END = 5'd15;

   logic signed [DW-1:0] x1, y1, x2, y2, dx, dy, ex, ey, hx1, tx1, hy1, ty1;
   logic signed [7:0] dirx, diry;
   logic [COORD_BITS-1:0] cmask;

   logic [SW-1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic signed [PW-1:0] acc_ff, acc_in, sh_ff, sh_in, st_ff, st_in, d_ff, d_in;
   logic signed [PW-1:0] dot_ff, dot_in, vx_ff, vx_in;
   logic [MW-1:0] mexx_ff, mexx_in, mss_lo_ff, mss_lo_in, mss_hi_ff, mss_hi_in;
   logic [WW-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic win_ff, win_in, wout_ff, wout_in;

   logic signed [MW-1:0] ma, mb;
   logic signed [2*MW-1:0] prod;
   logic [MW-1:0] ua, ub;
   logic [2*MW-1:0] uprod;

   function automatic logic [MW-1:0] magw(input logic signed [PW-1:0] v);
      magw = v[PW-1] ? MW'(-v) : MW'(v);
   endfunction

   assign cmask = '1;
   assign x1 = DW'(line_reg[0 +: PACK_BITS] & PACK_BITS'(cmask));
   assign y1 = DW'(line_reg[PACK_BITS +: PACK_BITS] & PACK_BITS'(cmask));
   assign x2 = DW'(line_reg[2*PACK_BITS +: PACK_BITS] & PACK_BITS'(cmask));
   assign y2 = DW'(line_reg[3*PACK_BITS +: PACK_BITS] & PACK_BITS'(cmask));
   assign dirx = line_reg[4*PACK_BITS +: 8];
   assign diry = line_reg[4*PACK_BITS+8 +: 8];
   assign dx = x2 - x1;
   assign dy = y2 - y1;
   assign ex = DW'(tail_x) - DW'(head_x);
   assign ey = DW'(tail_y) - DW'(head_y);
   assign hx1 = DW'(head_x) - x1;
   assign tx1 = DW'(tail_x) - x1;
   assign hy1 = DW'(head_y) - y1;
   assign ty1 = DW'(tail_y) - y1;

   // operand selection for the one shared signed multiplier
   always_comb begin
      ma = '0;
      mb = '0;
      case (step_ff)
         S_P0: begin ma = MW'(dx); mb = MW'(hy1); end
         S_P1: begin ma = MW'(dy); mb = MW'(hx1); end
         S_P2: begin ma = MW'(dx); mb = MW'(ty1); end
         S_P3: begin ma = MW'(dy); mb = MW'(tx1); end
         S_P4: begin ma = MW'(dx); mb = MW'(ey); end
         S_P5: begin ma = MW'(dy); mb = MW'(ex); end
         S_P6: begin ma = MW'(ex); mb = MW'(dirx); end
         S_P7: begin ma = MW'(ey); mb = MW'(diry); end
         S_P8: begin ma = MW'(hx1); mb = MW'(tx1); end
         S_P9: begin ma = MW'(hy1); mb = MW'(ty1); end
         default: begin ma = '0; mb = '0; end
      endcase
   end
   assign prod = ma * mb;

   // unsigned multiplier for the exact wide compare, split in halves
   always_comb begin
      ua = '0;
      ub = '0;
      case (step_ff)
         S_LO: begin ua = magw(sh_ff); ub = magw(st_ff); end
         S_HI: begin ua = mss_lo_ff; ub = mexx_ff; end
         S_RL: begin ua = magw(d_ff); ub = magw(d_ff); end
         S_RH: begin ua = mss_hi_ff; ub = mexx_ff; end
         default: begin ua = '0; ub = '0; end
      endcase
   end
   assign uprod = ua * ub;

   always_comb begin
      logic opp, vcnt, cnt;
      step_in = step_ff;
      busy_in = busy_ff;
      acc_in = acc_ff;
      sh_in = sh_ff;
      st_in = st_ff;
      d_in = d_ff;
      dot_in = dot_ff;
      vx_in = vx_ff;
      mexx_in = mexx_ff;
      mss_lo_in = mss_lo_ff;
      mss_hi_in = mss_hi_ff;
      lhs_in = lhs_ff;
      rhs_in = rhs_ff;
      win_in = win_ff;
      wout_in = wout_ff;
      opp = (sh_ff < 0 && st_ff > 0) || (sh_ff > 0 && st_ff < 0);
      vcnt = 1'b0;
      cnt = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = S_P0;
         mexx_in = MW'(magw(PW'(ex)) * magw(PW'(ex)));
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         case (step_ff)
            S_P0: acc_in = PW'(prod);
            S_P1: sh_in = acc_ff - PW'(prod);
            S_P2: acc_in = PW'(prod);
            S_P3: st_in = acc_ff - PW'(prod);
            S_P4: acc_in = PW'(prod);
            S_P5: d_in = acc_ff - PW'(prod);
            S_P6: acc_in = PW'(prod);
            S_P7: dot_in = acc_ff + PW'(prod);
            S_P8: vx_in = PW'(prod);
            S_P9: acc_in = PW'(prod);
            S_LO: begin
               mss_lo_in = uprod[MW-1:0];
               mss_hi_in = uprod[2*MW-1:MW];
            end
            S_HI: lhs_in = WW'(uprod);
            S_RL: rhs_in = WW'(uprod) * WW'(MARGIN);
            S_RH: lhs_in = lhs_ff + (WW'(uprod) << MW);
            S_DEC: begin
               if (dx == 0) begin
                  vcnt = (ex != 0) && (vx_ff < -PW'(MARGIN));
               end else if (dy == 0) begin
                  vcnt = (ey != 0) && (acc_ff < -PW'(MARGIN));
               end else if (ex == 0) begin
                  vcnt = opp;
               end else begin
                  vcnt = (d_ff != 0) && opp && (lhs_ff > rhs_ff);
               end
               cnt = vcnt;
               win_in = cnt && (dot_ff > 0);
               wout_in = cnt && (dot_ff < 0);
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= S_P0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
      sh_ff <= sh_in;
      st_ff <= st_in;
      d_ff <= d_in;
      dot_ff <= dot_in;
      vx_ff <= vx_in;
      mexx_ff <= mexx_in;
      mss_lo_ff <= mss_lo_in;
      mss_hi_ff <= mss_hi_in;
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
      win_ff <= win_in;
      wout_ff <= wout_in;
   end

   assign status.done = busy_ff && (step_ff == S_END);
   assign went_in = win_ff;
   assign went_out = wout_ff;

endmodule

// ===== sv/tlcc_control.sv =====
// Controller: walks the lines in use and hands out one result per line.
module tlcc_control
   import tlcc_pkg::*;
#(
   parameter int unsigned IDX_BITS = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                rsp_fire,
   input  logic [IDX_BITS:0]   lines_used,
   input  status_type          status,
   output cmd_type             cmd,
   output logic                req_ready,
   output logic                rsp_valid,
   output logic [IDX_BITS-1:0] index,
   output logic                is_last
);

   state_type state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;

   assign is_last = ({1'b0, idx_ff} + 1'b1) == lines_used;
   assign index = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) begin
            state_in = ST_CALC;
            idx_in = '0;
         end
         ST_CALC: if (status.done) state_in = ST_EMIT;
         ST_EMIT: if (rsp_fire) begin
            if (is_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CALC;
               idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_fire;
            cmd.start = req_fire;
         end
         ST_CALC: cmd.commit = status.done;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.start = rsp_fire && !is_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== sv/trajectory_line_crossing_counter.sv =====
// Top level: trajectory line-crossing counter.
// Each request carries a finished trajectory's head and tail; the block answers with
// one response per counting line in use, in line order, the last one marked by tlast.
// Lines are tested one after another on a shared multiplier: each line runs its arithmetic
// steps and then hands out its response, and the next line starts only once that response
// is taken, so a stalled response adds its stall.
// Counters saturate at 65535. Write configuration only while no request is in flight.
module trajectory_line_crossing_counter
   import tlcc_pkg::*;
#(
   parameter int unsigned MAX_LINES = 4,
   parameter int unsigned COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // head_x, head_y, tail_x, tail_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // line_index, went_in, went_out, total_in, total_out
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  logic [LINE_BITS-1:0]     csr_data
);

   localparam int unsigned IB = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

   cmd_type cmd;
   status_type status;
   logic [2:0] line_count_ff;
   logic [LINE_BITS-1:0] lines_ff [MAX_LINES];
   logic [CNT_BITS-1:0] cin_ff [MAX_LINES];
   logic [CNT_BITS-1:0] cout_ff [MAX_LINES];
   logic [COORD_BITS-1:0] hx_ff, hy_ff, tx_ff, ty_ff;
   logic [COORD_BITS-1:0] in_hx, in_hy, in_tx, in_ty;
   logic [IB:0] used;
   logic [IB-1:0] idx;
   logic is_last, win, wout, req_fire, rsp_fire;
   logic [LINE_BITS-1:0] cur_line;

   assign csr_ready = 1'b1;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   assign in_hx = COORD_BITS'(req_tdata[0 +: PACK_BITS]);
   assign in_hy = COORD_BITS'(req_tdata[PACK_BITS +: PACK_BITS]);
   assign in_tx = COORD_BITS'(req_tdata[2*PACK_BITS +: PACK_BITS]);
   assign in_ty = COORD_BITS'(req_tdata[3*PACK_BITS +: PACK_BITS]);

   always_comb begin
      if (line_count_ff == 3'd0) used = (IB+1)'(1);
      else if (32'(line_count_ff) > MAX_LINES) used = (IB+1)'(MAX_LINES);
      else used = (IB+1)'(line_count_ff);
   end

   assign cur_line = lines_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= 3'd1;
         for (int i = 0; i < MAX_LINES; i++) begin
            lines_ff[i] <= '0;
            cin_ff[i] <= '0;
            cout_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LINE_COUNT) begin
               line_count_ff <= csr_data[2:0];
            end else begin
               for (int i = 0; i < MAX_LINES; i++) begin
                  if (i < LINE_REGS && 32'(csr_index) == i + 1) lines_ff[i] <= csr_data;
               end
            end
         end
         if (cmd.commit) begin
            if (win && cin_ff[idx] != '1) cin_ff[idx] <= cin_ff[idx] + 1'b1;
            if (wout && cout_ff[idx] != '1) cout_ff[idx] <= cout_ff[idx] + 1'b1;
         end
      end
      if (cmd.load) begin
         hx_ff <= in_hx;
         hy_ff <= in_hy;
         tx_ff <= in_tx;
         ty_ff <= in_ty;
      end
   end

   tlcc_control #(.IDX_BITS(IB)) u_ctrl (
      .clock, .reset, .req_fire, .rsp_fire, .lines_used(used), .status, .cmd,
      .req_ready(req_tready), .rsp_valid(rsp_tvalid), .index(idx), .is_last
   );

   tlcc_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
      .clock, .reset, .cmd, .status, .line_reg(cur_line),
      .head_x(cmd.load ? in_hx : hx_ff),
      .head_y(cmd.load ? in_hy : hy_ff),
      .tail_x(cmd.load ? in_tx : tx_ff),
      .tail_y(cmd.load ? in_ty : ty_ff),
      .went_in(win), .went_out(wout)
   );

   assign rsp_tdata = {4'd0, cout_ff[idx], cin_ff[idx], wout, win, 2'(idx)};
   assign rsp_tlast = is_last;

endmodule
